// ===== design/sorted_list_insert_delete_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted list core assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLID_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list core: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list core: next-cycle check failed");

`endif

// ===== design/slid_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list package
// Word types, command codes, status codes and default sizes.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_VALUE_BITS = 16;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 16;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;

  localparam logic [OP_W-1:0] OP_DEL  = 2'd0;
  localparam logic [OP_W-1:0] OP_INS  = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROP_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROP_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   slot_value;
    logic [POS_W-1:0]    position;
    logic                last;
  } res_word_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
  } cell_ctrl_t;

endpackage

// ===== design/slid_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one list entry, compares it with the search value, and loads from
// its lower or upper neighbor on insert, delete and dump rotation.
// ----------------------------------------------------------------------------
module slid_cell #(
  parameter int VALUE_BITS = slid_pkg::DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  slid_pkg::cell_ctrl_t  ctrl,
  input  logic [VALUE_BITS-1:0] v,
  input  logic [VALUE_BITS-1:0] prev_entry,
  input  logic                  prev_ge,
  input  logic [VALUE_BITS-1:0] next_entry,
  output logic [VALUE_BITS-1:0] entry,
  output logic                  ge,
  output logic                  eq
);
  import slid_pkg::*;

  logic [VALUE_BITS-1:0] entry_next;

  assign ge = (entry == '0) || (entry >= v);
  assign eq = (entry == v);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (prev_ge) begin
        entry_next = prev_entry;
      end else if (ge) begin
        entry_next = v;
      end
    end else if (ctrl.del) begin
      if (ge) begin
        entry_next = next_entry;
      end
    end else if (ctrl.rot) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

// ===== design/sorted_list_insert_delete_core.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert/delete core
// An insert, a delete, a zero-value reject or an unused op code is handled
// in the cycle it is taken, and a new word is taken every cycle as long as
// the result register is drained; every cell compares against the value in
// parallel and shifts toward its neighbor in that same cycle. A dump holds
// off the command side for CAPACITY result words: the row of cells rotates
// one place per word so that each entry passes through cell 0, and after a
// full turn the list is back in place. List contents are cleared by reset.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_core #(
  parameter int CAPACITY   = slid_pkg::DEF_CAPACITY,
  parameter int VALUE_BITS = slid_pkg::DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  slid_pkg::cmd_word_t cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output slid_pkg::res_word_t res
);
  import slid_pkg::*;
  `include "sorted_list_insert_delete_core_defines.svh"

  localparam int CNT_W = $clog2(CAPACITY);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                  state;
  logic                  state_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic                  res_valid_next;
  res_word_t             res_next;

  logic                  adv;
  logic                  cmd_fire;
  logic [VALUE_BITS-1:0] v;
  logic                  v_zero;
  logic [DATA_W-1:0]     v_slot;
  logic [DATA_W-1:0]     head_slot;
  logic [POS_W-1:0]      cnt_pos;
  cell_ctrl_t            ctrl;

  logic [VALUE_BITS-1:0] entry_q [CAPACITY];
  logic [CAPACITY-1:0]   ge_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic [CAPACITY-1:0]   first_vec;
  logic                  found;
  logic [POS_W-1:0]      hit_pos;

  assign adv       = !res_valid || res_ready;
  assign cmd_ready = (state == ST_IDLE) && adv;
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign v         = VALUE_BITS'({{32{1'b0}}, cmd.value});
  assign v_zero    = (v == '0);
  assign v_slot    = DATA_W'({{DATA_W{1'b0}}, v});
  assign head_slot = DATA_W'({{DATA_W{1'b0}}, entry_q[0]});
  assign cnt_pos   = POS_W'({{POS_W{1'b0}}, cnt});

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] prev_entry;
    logic                  prev_ge;
    logic [VALUE_BITS-1:0] next_entry;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_ge    = 1'b0;
    end else begin : g_body
      assign prev_entry = entry_q[i-1];
      assign prev_ge    = ge_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = ctrl.rot ? entry_q[0] : '0;
    end else begin : g_inner
      assign next_entry = entry_q[i+1];
    end

    assign first_vec[i] = ge_vec[i] && !prev_ge;

    slid_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .v          (v),
      .prev_entry (prev_entry),
      .prev_ge    (prev_ge),
      .next_entry (next_entry),
      .entry      (entry_q[i]),
      .ge         (ge_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  always_comb begin
    found   = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | (first_vec[i] & eq_vec[i]);
      if (first_vec[i]) begin
        hit_pos = hit_pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    ctrl.ins = cmd_fire && (cmd.op == OP_INS) && !v_zero;
    ctrl.del = cmd_fire && (cmd.op == OP_DEL) && !v_zero && found;
    ctrl.rot = (state == ST_DUMP) && adv;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    res_valid_next = res_valid && !res_ready;
    res_next       = res;

    if (cmd_fire) begin
      case (cmd.op)
        OP_INS: begin
          res_valid_next  = 1'b1;
          res_next.last   = 1'b1;
          if (v_zero) begin
            res_next.status     = ST_ZERO;
            res_next.slot_value = '0;
            res_next.position   = '0;
          end else if (!ge_vec[CAPACITY-1]) begin
            res_next.status     = ST_DROP_FULL;
            res_next.slot_value = v_slot;
            res_next.position   = '0;
          end else begin
            res_next.status     = (entry_q[CAPACITY-1] != '0) ? ST_DROP_LARGE : ST_OK;
            res_next.slot_value = v_slot;
            res_next.position   = hit_pos;
          end
        end
        OP_DEL: begin
          res_valid_next  = 1'b1;
          res_next.last   = 1'b1;
          if (v_zero) begin
            res_next.status     = ST_ZERO;
            res_next.slot_value = '0;
            res_next.position   = '0;
          end else if (found) begin
            res_next.status     = ST_OK;
            res_next.slot_value = v_slot;
            res_next.position   = hit_pos;
          end else begin
            res_next.status     = ST_NOT_FOUND;
            res_next.slot_value = v_slot;
            res_next.position   = '0;
          end
        end
        OP_DUMP: begin
          state_next = ST_DUMP;
          cnt_next   = '0;
        end
        default: begin
        end
      endcase
    end else if (ctrl.rot) begin
      res_valid_next      = 1'b1;
      res_next.status     = ST_OK;
      res_next.slot_value = head_slot;
      res_next.position   = cnt_pos;
      res_next.last       = (cnt == CNT_W'(CAPACITY - 1));
      cnt_next            = cnt + 1'b1;
      if (cnt == CNT_W'(CAPACITY - 1)) begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  `SLID_ASSERT_SAME(a_single_first, state == ST_IDLE, $onehot0(first_vec))
  `SLID_ASSERT_SAME(a_no_cmd_in_dump, state == ST_DUMP, !cmd_ready)
  `SLID_ASSERT_NEXT(a_edit_gives_result, cmd_fire && (cmd.op == OP_INS || cmd.op == OP_DEL), res_valid)

endmodule
